### hdl/ssrc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssrc_pkg
// Shared types and constants of the shadow stack return check block.
// ----------------------------------------------------------------------------
package ssrc_pkg;

  localparam int STACK_DEPTH_DEF = 1024;
  localparam int ADDR_W          = 64;
  localparam int CNT_OUT_W       = 11;
  localparam int RUN_W           = 8;

  localparam logic [RUN_W-1:0] RUN_LIMIT_RESET = 8'd60;
  localparam logic [RUN_W-1:0] RUN_MAX         = 8'd255;

  localparam logic MODE_CALL   = 1'b0;
  localparam logic MODE_RETURN = 1'b1;

  typedef enum logic [1:0] {
    V_PUSHED   = 2'd0,
    V_VALID    = 2'd1,
    V_INVALID  = 2'd2,
    V_OVERFLOW = 2'd3
  } verdict_t;

  typedef enum logic {
    ST_IDLE  = 1'b0,
    ST_CHECK = 1'b1
  } seq_state_t;

  typedef struct packed {
    verdict_t               verdict;
    logic                   run_alert;
    logic [CNT_OUT_W-1:0]   entries_unwound;
    logic [CNT_OUT_W-1:0]   stack_depth;
  } result_t;

endpackage

### hdl/ssrc_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssrc_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module ssrc_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

### hdl/ssrc_seq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssrc_seq
// Sequencer: stack pointer, run counter and the shared top-of-stack compare.
// ----------------------------------------------------------------------------
module ssrc_seq #(
  parameter int STACK_DEPTH = ssrc_pkg::STACK_DEPTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  input  logic                               start_mode,
  input  logic [ssrc_pkg::ADDR_W-1:0]        start_addr,
  input  logic [ssrc_pkg::RUN_W-1:0]         run_limit,
  output logic                               idle,
  output logic                               ram_wr_en,
  output logic [$clog2(STACK_DEPTH)-1:0]     ram_wr_addr,
  output logic [$clog2(STACK_DEPTH)-1:0]     ram_rd_addr,
  input  logic [ssrc_pkg::ADDR_W-1:0]        ram_rd_data,
  output logic                               res_load,
  output ssrc_pkg::result_t                  res
);

  localparam int AW = $clog2(STACK_DEPTH);
  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam int OW = ssrc_pkg::CNT_OUT_W;
  localparam logic [CW-1:0] FULL = CW'(STACK_DEPTH);

  ssrc_pkg::seq_state_t state_r, state_nxt;
  logic [CW-1:0]                count_r, count_nxt;
  logic [CW-1:0]                unwound_r, unwound_nxt;
  logic [ssrc_pkg::RUN_W-1:0]   run_r, run_nxt;
  logic [ssrc_pkg::ADDR_W-1:0]  addr_r, addr_nxt;
  logic [CW-1:0]                count_dec;
  logic [ssrc_pkg::RUN_W-1:0]   run_inc;

  assign count_dec = count_r - 1'b1;
  assign run_inc   = (run_r == ssrc_pkg::RUN_MAX) ? run_r : run_r + 1'b1;
  assign idle      = (state_r == ssrc_pkg::ST_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ssrc_pkg::ST_IDLE;
      count_r <= '0;
      run_r   <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      run_r   <= run_nxt;
    end
  end

  always_ff @(posedge clk) begin
    unwound_r <= unwound_nxt;
    addr_r    <= addr_nxt;
  end

  always_comb begin
    state_nxt       = state_r;
    count_nxt       = count_r;
    run_nxt         = run_r;
    unwound_nxt     = unwound_r;
    addr_nxt        = addr_r;
    ram_wr_en       = 1'b0;
    ram_wr_addr     = count_r[AW-1:0];
    ram_rd_addr     = count_dec[AW-1:0];
    res_load        = 1'b0;
    res.verdict     = ssrc_pkg::V_PUSHED;
    res.run_alert   = 1'b0;
    res.entries_unwound = '0;
    res.stack_depth = OW'(count_r);
    case (state_r)
      ssrc_pkg::ST_IDLE: begin
        if (start) begin
          if (start_mode == ssrc_pkg::MODE_CALL) begin
            run_nxt  = '0;
            res_load = 1'b1;
            if (count_r >= FULL) begin
              res.verdict = ssrc_pkg::V_OVERFLOW;
            end else begin
              ram_wr_en       = 1'b1;
              count_nxt       = count_r + 1'b1;
              res.stack_depth = OW'(count_nxt);
            end
          end else if (count_r == '0) begin
            // return on an empty stack
            run_nxt         = '0;
            res_load        = 1'b1;
            res.verdict     = ssrc_pkg::V_INVALID;
            res.stack_depth = '0;
          end else begin
            addr_nxt    = start_addr;
            count_nxt   = count_dec;
            unwound_nxt = CW'(1);
            state_nxt   = ssrc_pkg::ST_CHECK;
          end
        end
      end
      ssrc_pkg::ST_CHECK: begin
        if (ram_rd_data == addr_r) begin
          run_nxt             = run_inc;
          res_load            = 1'b1;
          res.verdict         = ssrc_pkg::V_VALID;
          res.run_alert       = (run_inc > run_limit);
          res.entries_unwound = OW'(unwound_r);
          state_nxt           = ssrc_pkg::ST_IDLE;
        end else if (count_r == '0) begin
          run_nxt             = '0;
          res_load            = 1'b1;
          res.verdict         = ssrc_pkg::V_INVALID;
          res.entries_unwound = OW'(unwound_r);
          res.stack_depth     = '0;
          state_nxt           = ssrc_pkg::ST_IDLE;
        end else begin
          // pop the next stale entry and look again
          count_nxt   = count_dec;
          unwound_nxt = unwound_r + 1'b1;
        end
      end
      default: begin
        state_nxt = ssrc_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

### hdl/shadow_stack_return_check_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shadow_stack_return_check_core
// Return address shadow stack with call push, return unwind and run alert.
// ----------------------------------------------------------------------------
//  channel  | handshake             | payload
//  ---------+-----------------------+------------------------------------------
//  in       | in_valid / in_ready   | in_mode, in_address
//  out      | out_valid / out_ready | out_verdict, out_run_alert,
//           |                       | out_entries_unwound, out_stack_depth
//  cfg      | cfg_wr_en             | cfg_wr_data (run_limit)
//
// a call is answered straight from idle; a return pops one entry per step,
// each step a registered stack ram read and compare of the top entry.
// the result sits in an output register; the next item is taken once the
// sequencer is idle and that register is free or being taken in the same cycle.
// reset is synchronous; the stack ram needs no clearing, reset empties the
// pointer and the run counter, clears state and out_valid, sets run_limit to 60.
// ----------------------------------------------------------------------------
module shadow_stack_return_check_core #(
  parameter int STACK_DEPTH = ssrc_pkg::STACK_DEPTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic                               in_mode,
  input  logic [ssrc_pkg::ADDR_W-1:0]        in_address,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [1:0]                         out_verdict,
  output logic                               out_run_alert,
  output logic [ssrc_pkg::CNT_OUT_W-1:0]     out_entries_unwound,
  output logic [ssrc_pkg::CNT_OUT_W-1:0]     out_stack_depth,
  input  logic                               cfg_wr_en,
  input  logic [ssrc_pkg::RUN_W-1:0]         cfg_wr_data
);

  localparam int AW = $clog2(STACK_DEPTH);

  logic [ssrc_pkg::RUN_W-1:0]   run_limit_r;
  logic                         out_valid_r, out_valid_nxt;
  ssrc_pkg::result_t            out_r;
  ssrc_pkg::result_t            res;
  logic                         res_load;
  logic                         seq_idle;
  logic                         in_accept;
  logic                         ram_wr_en;
  logic [AW-1:0]                ram_wr_addr;
  logic [AW-1:0]                ram_rd_addr;
  logic [ssrc_pkg::ADDR_W-1:0]  ram_rd_data;

  assign in_ready  = seq_idle && (!out_valid_r || out_ready);
  assign in_accept = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_limit_r <= ssrc_pkg::RUN_LIMIT_RESET;
    end else if (cfg_wr_en) begin
      run_limit_r <= cfg_wr_data;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      out_r <= res;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_verdict         = out_r.verdict;
  assign out_run_alert       = out_r.run_alert;
  assign out_entries_unwound = out_r.entries_unwound;
  assign out_stack_depth     = out_r.stack_depth;

  ssrc_seq #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_seq (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (in_accept),
    .start_mode  (in_mode),
    .start_addr  (in_address),
    .run_limit   (run_limit_r),
    .idle        (seq_idle),
    .ram_wr_en   (ram_wr_en),
    .ram_wr_addr (ram_wr_addr),
    .ram_rd_addr (ram_rd_addr),
    .ram_rd_data (ram_rd_data),
    .res_load    (res_load),
    .res         (res)
  );

  ssrc_ram #(
    .WIDTH (ssrc_pkg::ADDR_W),
    .DEPTH (STACK_DEPTH)
  ) u_stack_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (in_address),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  // a finished result never lands on one that is still waiting
  a_no_result_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    res_load |-> (!out_valid_r || out_ready))
    else $error("result loaded over a pending item");

  // a call is answered in the following cycle
  a_call_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && in_mode == ssrc_pkg::MODE_CALL) |=> out_valid)
    else $error("call result missing");

  // a violation always leaves the stack empty
  a_invalid_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_verdict == ssrc_pkg::V_INVALID) |-> (out_stack_depth == '0))
    else $error("invalid return with nonzero depth");

  // calls pop nothing and never alert
  a_call_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_verdict == ssrc_pkg::V_PUSHED ||
                   out_verdict == ssrc_pkg::V_OVERFLOW))
    |-> (out_entries_unwound == '0 && !out_run_alert))
    else $error("call result with unwind or alert");

endmodule

### verif/shadow_stack_return_check_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shadow_stack_return_check_core_tb
// Drives call and return items into the shadow stack under random input and
// output stalls, predicts every verdict with a behavioral copy of the stack,
// run counter and run limit, and compares each result field by field. Covers
// empty-stack returns, stale-entry unwinds, violations, run saturation with
// the alert held at the top and random call/return traffic under several
// run limits.
// ----------------------------------------------------------------------------
module shadow_stack_return_check_core_tb;

  localparam int STACK_DEPTH   = ssrc_pkg::STACK_DEPTH_DEF;
  localparam int ADDR_W        = ssrc_pkg::ADDR_W;
  localparam int CNT_OUT_W     = ssrc_pkg::CNT_OUT_W;
  localparam int RUN_W         = ssrc_pkg::RUN_W;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int SETTLE_CYCLES = 20;
  localparam int SAT_CALLS     = 256;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic                 in_mode = ssrc_pkg::MODE_CALL;
  logic [ADDR_W-1:0]    in_address = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [1:0]           out_verdict;
  logic                 out_run_alert;
  logic [CNT_OUT_W-1:0] out_entries_unwound;
  logic [CNT_OUT_W-1:0] out_stack_depth;
  logic                 cfg_wr_en = 1'b0;
  logic [RUN_W-1:0]     cfg_wr_data = '0;

  // behavioral copy of the block state
  logic [ADDR_W-1:0] shadow_mem [STACK_DEPTH];
  int unsigned       shadow_count = 0;
  logic [RUN_W-1:0]  run_count = '0;
  logic [RUN_W-1:0]  limit_model = ssrc_pkg::RUN_LIMIT_RESET;

  ssrc_pkg::result_t expected_verdicts [$];
  int                error_count = 0;
  int unsigned       items_sent = 0;
  int unsigned       cycle_count = 0;
  bit                stall_enable = 1'b1;
  int unsigned       ready_hold = 0;

  shadow_stack_return_check_core dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_mode             (in_mode),
    .in_address          (in_address),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_verdict         (out_verdict),
    .out_run_alert       (out_run_alert),
    .out_entries_unwound (out_entries_unwound),
    .out_stack_depth     (out_stack_depth),
    .cfg_wr_en           (cfg_wr_en),
    .cfg_wr_data         (cfg_wr_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // result side back-pressure in random bursts
  always @(posedge clk) begin
    if (ready_hold != 0) begin
      out_ready  <= 1'b0;
      ready_hold <= ready_hold - 1;
    end else if (stall_enable && $urandom_range(0, 6) == 0) begin
      out_ready  <= 1'b0;
      ready_hold <= $urandom_range(0, 2);
    end else begin
      out_ready <= 1'b1;
    end
  end

  function automatic ssrc_pkg::result_t predict_verdict(input logic mode,
                                                        input logic [ADDR_W-1:0] addr);
    ssrc_pkg::result_t r;
    int unsigned       unwound;
    r = '{verdict: ssrc_pkg::V_PUSHED, run_alert: 1'b0, entries_unwound: '0,
          stack_depth: '0};
    if (mode == ssrc_pkg::MODE_CALL) begin
      run_count = '0;
      if (shadow_count >= STACK_DEPTH) begin
        r.verdict = ssrc_pkg::V_OVERFLOW;
      end else begin
        shadow_mem[shadow_count] = addr;
        shadow_count++;
      end
      r.stack_depth = CNT_OUT_W'(shadow_count);
      return r;
    end
    unwound = 0;
    while (shadow_count > 0) begin
      shadow_count--;
      unwound++;
      if (shadow_mem[shadow_count] == addr) begin
        if (run_count != ssrc_pkg::RUN_MAX) run_count++;
        r.verdict         = ssrc_pkg::V_VALID;
        r.run_alert       = (run_count > limit_model);
        r.entries_unwound = CNT_OUT_W'(unwound);
        r.stack_depth     = CNT_OUT_W'(shadow_count);
        return r;
      end
    end
    // stack ran dry without a match
    run_count         = '0;
    r.verdict         = ssrc_pkg::V_INVALID;
    r.entries_unwound = CNT_OUT_W'(unwound);
    return r;
  endfunction

  task automatic check_field(input string field, input int unsigned want, input int unsigned got);
    if (want != got) begin
      error_count++;
      $display("%0t ns: %s expected %0d, got %0d", $time, field, want, got);
    end
  endtask

  always @(posedge clk) begin : result_checker
    ssrc_pkg::result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_verdicts.size() == 0) begin
        error_count++;
        $display("%0t ns: unexpected result, expected none, got verdict %0d depth %0d",
                 $time, out_verdict, out_stack_depth);
      end else begin
        want = expected_verdicts.pop_front();
        check_field("verdict", want.verdict, out_verdict);
        check_field("run_alert", want.run_alert, out_run_alert);
        check_field("entries_unwound", want.entries_unwound, out_entries_unwound);
        check_field("stack_depth", want.stack_depth, out_stack_depth);
      end
    end
  end

  task automatic send_item(input logic mode, input logic [ADDR_W-1:0] addr);
    if (stall_enable && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_mode    <= mode;
    in_address <= addr;
    do @(posedge clk); while (!in_ready);
    // valid stays up; the next call either replaces the payload or lowers it
    expected_verdicts.push_back(predict_verdict(mode, addr));
    items_sent++;
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (expected_verdicts.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_limit(input logic [RUN_W-1:0] value);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    limit_model = value;
  endtask

  // small values repeat often so returns hit older copies of an address
  function automatic logic [ADDR_W-1:0] rand_addr();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      2:       return ADDR_W'($urandom_range(0, 7));
      default: return {$urandom, $urandom};
    endcase
  endfunction

  task automatic test_directed();
    send_item(ssrc_pkg::MODE_RETURN, 64'h0);                    // empty stack
    send_item(ssrc_pkg::MODE_RETURN, 64'hFFFF_FFFF_FFFF_FFFF);
    send_item(ssrc_pkg::MODE_CALL,   64'hFFFF_FFFF_FFFF_FFFF);
    send_item(ssrc_pkg::MODE_CALL,   64'h0);
    send_item(ssrc_pkg::MODE_CALL,   64'h8000_0000_0000_0001);
    send_item(ssrc_pkg::MODE_RETURN, 64'h0);                    // unwinds past a stale entry
    send_item(ssrc_pkg::MODE_RETURN, 64'hFFFF_FFFF_FFFF_FFFF);
    send_item(ssrc_pkg::MODE_CALL,   64'h5555_5555_5555_5555);
    send_item(ssrc_pkg::MODE_CALL,   64'hAAAA_AAAA_AAAA_AAAA);
    send_item(ssrc_pkg::MODE_CALL,   64'h5555_5555_5555_5555);
    send_item(ssrc_pkg::MODE_RETURN, 64'h5555_5555_5555_5555);  // top copy matches first
    send_item(ssrc_pkg::MODE_RETURN, 64'h5555_5555_5555_5555);
    send_item(ssrc_pkg::MODE_CALL,   64'h1);
    send_item(ssrc_pkg::MODE_CALL,   64'h2);
    send_item(ssrc_pkg::MODE_RETURN, 64'h3);                    // violation empties the stack
    send_item(ssrc_pkg::MODE_CALL,   64'h7);
    send_item(ssrc_pkg::MODE_RETURN, 64'h7);
    send_item(ssrc_pkg::MODE_RETURN, 64'h7);
    drain_results();
  endtask

  // enough valid returns in a row to reach the run ceiling and stay there
  task automatic test_run_saturation(input logic [RUN_W-1:0] limit);
    write_limit(limit);
    repeat (SAT_CALLS) send_item(ssrc_pkg::MODE_CALL, {$urandom, $urandom});
    while (shadow_count != 0)
      send_item(ssrc_pkg::MODE_RETURN, shadow_mem[shadow_count - 1]);
    drain_results();
  endtask

  task automatic test_random_traffic(input logic [RUN_W-1:0] limit, input int unsigned count,
                                     input bit idle);
    int unsigned target;
    int unsigned calls;
    int unsigned back;
    write_limit(limit);
    stall_enable = idle;
    target = items_sent + count;
    while (items_sent < target) begin
      if ($urandom_range(0, 9) == 0) begin
        send_item(logic'($urandom_range(0, 1)), rand_addr());
      end else begin
        calls = $urandom_range(1, 8);
        repeat (calls) send_item(ssrc_pkg::MODE_CALL, rand_addr());
        repeat ($urandom_range(1, calls + 1)) begin
          if (shadow_count != 0 && $urandom_range(0, 9) != 0) begin
            back = $urandom_range(0, 2);
            if (back >= shadow_count) back = 0;
            send_item(ssrc_pkg::MODE_RETURN, shadow_mem[shadow_count - 1 - back]);
          end else begin
            send_item(ssrc_pkg::MODE_RETURN, rand_addr());
          end
        end
      end
    end
    drain_results();
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_run_saturation(ssrc_pkg::RUN_MAX - 8'd1);
    test_random_traffic(RUN_W'($urandom_range(0, 3)), 40, 1'b1);
    test_random_traffic(RUN_W'($urandom_range(2, 10)), 30, 1'b0);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (error_count == 0 && expected_verdicts.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
